// File: rtl/core/tcfx_pkg.sv
package tcfx_pkg;

  // Fine period ROM geometry: eight fine steps per semitone.
  localparam int SEMITONES  = 144;
  localparam int FINE_SHIFT = 3;
  localparam int FINE_STEPS = 1 << FINE_SHIFT;
  localparam int ROM_LEN    = SEMITONES * FINE_STEPS;
  localparam int ROM_AW     = 11;

  localparam logic [15:0] PERIOD_RESET   = 16'd448;
  localparam logic [15:0] PERIOD_MIN     = 16'd113;
  localparam logic [15:0] PERIOD_FINE_HI = 16'd856;
  localparam logic [15:0] PERIOD_MAX     = 16'd20000;
  localparam logic [7:0]  VOL_MAX        = 8'd64;
  localparam logic [7:0]  VOL_TONE_MAX   = 8'd63;
  localparam logic [7:0]  VOL_WRAP_LIM   = 8'd200;
  localparam logic [7:0]  SPEED_LIMIT    = 8'h21;

  // Command codes.
  localparam logic [1:0] CMD_NOTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_LOAD = 2'd2;

  // Effect nibbles.
  localparam logic [3:0] FX_ARP       = 4'h0;
  localparam logic [3:0] FX_PORT_UP   = 4'h1;
  localparam logic [3:0] FX_PORT_DN   = 4'h2;
  localparam logic [3:0] FX_TONE      = 4'h3;
  localparam logic [3:0] FX_VIB       = 4'h4;
  localparam logic [3:0] FX_TONE_VOL  = 4'h5;
  localparam logic [3:0] FX_VIB_VOL   = 4'h6;
  localparam logic [3:0] FX_OFFSET    = 4'h9;
  localparam logic [3:0] FX_VOL_SLIDE = 4'hA;
  localparam logic [3:0] FX_JUMP      = 4'hB;
  localparam logic [3:0] FX_SET_VOL   = 4'hC;
  localparam logic [3:0] FX_BREAK     = 4'hD;
  localparam logic [3:0] FX_EXT       = 4'hE;
  localparam logic [3:0] FX_SPEED     = 4'hF;

  // Extended effect sub-codes.
  localparam logic [3:0] EX_FINE_UP = 4'h1;
  localparam logic [3:0] EX_FINE_DN = 4'h2;
  localparam logic [3:0] EX_LOOP    = 4'h6;
  localparam logic [3:0] EX_FVOL_UP = 4'hA;
  localparam logic [3:0] EX_FVOL_DN = 4'hB;
  localparam logic [3:0] EX_DELAY   = 4'hE;

  // Song-flow codes.
  localparam logic [2:0] FLOW_NONE  = 3'd0;
  localparam logic [2:0] FLOW_JUMP  = 3'd1;
  localparam logic [2:0] FLOW_BREAK = 3'd2;
  localparam logic [2:0] FLOW_LOOP  = 3'd3;
  localparam logic [2:0] FLOW_DELAY = 3'd4;
  localparam logic [2:0] FLOW_SPEED = 3'd5;
  localparam logic [2:0] FLOW_TEMPO = 3'd6;

  localparam logic [15:0] BASE_PERIOD [SEMITONES] = '{
    16'd27392,16'd25856,16'd24384,16'd23040,16'd21696,16'd20480,16'd19328,16'd18240,
    16'd17216,16'd16256,16'd15360,16'd14496,16'd13696,16'd12928,16'd12192,16'd11520,
    16'd10848,16'd10240,16'd9664,16'd9120,16'd8606,16'd8128,16'd7680,16'd7248,
    16'd6848,16'd6464,16'd6096,16'd5760,16'd5424,16'd5120,16'd4832,16'd4560,
    16'd4304,16'd4064,16'd3840,16'd3624,16'd3424,16'd3232,16'd3048,16'd2880,
    16'd2712,16'd2560,16'd2416,16'd2280,16'd2152,16'd2032,16'd1920,16'd1812,
    16'd1712,16'd1616,16'd1524,16'd1440,16'd1356,16'd1280,16'd1208,16'd1140,
    16'd1076,16'd1016,16'd960,16'd906,16'd856,16'd808,16'd762,16'd720,
    16'd678,16'd640,16'd604,16'd570,16'd538,16'd508,16'd480,16'd453,
    16'd428,16'd404,16'd381,16'd360,16'd339,16'd320,16'd302,16'd285,
    16'd269,16'd254,16'd240,16'd226,16'd214,16'd202,16'd190,16'd180,
    16'd170,16'd160,16'd151,16'd143,16'd135,16'd127,16'd120,16'd113,
    16'd107,16'd101,16'd95,16'd90,16'd85,16'd80,16'd75,16'd71,
    16'd67,16'd63,16'd60,16'd56,16'd53,16'd50,16'd47,16'd45,
    16'd42,16'd40,16'd37,16'd35,16'd33,16'd31,16'd30,16'd28,
    16'd27,16'd25,16'd24,16'd22,16'd21,16'd20,16'd19,16'd18,
    16'd17,16'd16,16'd15,16'd14,16'd13,16'd13,16'd12,16'd11,
    16'd11,16'd10,16'd9,16'd9,16'd8,16'd8,16'd7,16'd7
  };

  localparam logic [7:0] SINE_HALF [32] = '{
    8'd0,8'd24,8'd49,8'd74,8'd97,8'd120,8'd141,8'd161,
    8'd180,8'd197,8'd212,8'd224,8'd235,8'd244,8'd250,8'd253,
    8'd255,8'd253,8'd250,8'd244,8'd235,8'd224,8'd212,8'd197,
    8'd180,8'd161,8'd141,8'd120,8'd97,8'd74,8'd49,8'd24
  };

  // Per-channel state record.
  typedef struct packed {
    logic [15:0]      period;
    logic [7:0]       volume;
    logic [4:0]       instr;
    logic [3:0]       finetune;
    logic [3:0]       effect;
    logic [7:0]       param;
    logic [15:0]      arp_off;
    logic [2:0][15:0] arp;
    logic [1:0]       arp_step;
    logic [7:0]       slide_speed;
    logic [15:0]      slide_target;
    logic [15:0]      vib_off;
    logic [7:0]       vib_param;
    logic [5:0]       vib_phase;
    logic [7:0]       vol_slide;
  } chan_rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic fetch;
    logic note_a;
    logic ft_eval;
    logic ft_apply;
    logic note_b;
    logic arp_start;
    logic arp_x;
    logic arp_y;
    logic arp_z;
    logic tick;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       chan_ok;
    logic       need_ft;
    logic       need_arp;
    logic       search_done;
  } dp_stat_t;

  // One entry of the fine period ROM, built from the semitone table.
  function automatic logic [15:0] rom_entry(input logic [ROM_AW-1:0] idx);
    logic [7:0]  s;
    logic [2:0]  j;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] d;
    s = idx[ROM_AW-1:FINE_SHIFT];
    j = idx[FINE_SHIFT-1:0];
    if (s >= 8'(SEMITONES - 1)) begin
      return 16'd0;
    end
    a = BASE_PERIOD[s];
    b = BASE_PERIOD[8'(s + 8'd1)];
    d = (a - b) >> FINE_SHIFT;
    return 16'(a - 16'(d * {13'd0, j}));
  endfunction

  // Volume slide step: up by the high nibble, else down by the masked low part.
  function automatic logic [7:0] vol_step(input logic [7:0] vol, input logic [7:0] vs,
                                          input logic [7:0] up_lim, input logic [7:0] mask,
                                          input logic [7:0] dn_lim);
    logic [7:0] s;
    if (vs > 8'h0F) begin
      s = vol + {4'd0, vs[7:4]};
      return (s > up_lim) ? up_lim : s;
    end
    s = vol - (vs & mask);
    return (s > dn_lim) ? 8'd0 : s;
  endfunction

endpackage

// File: rtl/core/tracker_channel_effect_engine_top.sv
// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   cmd, chan, instrument, note_period, effect_word,
//                                    default_volume, default_finetune
// out      out_valid_o / out_ready_i chan_out, play_period, play_volume, sample_sel,
//                                    restart, start_offset, flow_code, flow_param
//
// One request at a time. Load and idle requests pass from fetch to the output state, a tick
// adds the tick step, and a note adds the note steps plus, where needed, a finetune search and
// an arpeggio setup, each an 11-step binary search over the 1152-entry fine period ROM.
// The result sits in an output register; a stalled output holds the next result in the
// last state until the register frees. Reset needs no clearing pass: channel entries
// carry valid bits and read as their reset values until first written.
module tracker_channel_effect_engine_top import tcfx_pkg::*; #(
  parameter int CHANNELS    = 32,
  parameter int INSTRUMENTS = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [4:0]         chan_i,
  input  logic [4:0]         instrument_i,
  input  logic [11:0]        note_period_i,
  input  logic [11:0]        effect_word_i,
  input  logic [6:0]         default_volume_i,
  input  logic [3:0]         default_finetune_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [4:0]         chan_out_o,
  output logic signed [15:0] play_period_o,
  output logic [7:0]         play_volume_o,
  output logic [4:0]         sample_sel_o,
  output logic               restart_o,
  output logic [15:0]        start_offset_o,
  output logic [2:0]         flow_code_o,
  output logic [7:0]         flow_param_o
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  tcfx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (ctrl_cmd)
  );

  tcfx_dp #(
    .CHANNELS    (CHANNELS),
    .INSTRUMENTS (INSTRUMENTS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (ctrl_cmd),
    .stat_o             (dp_stat),
    .cmd_in_i           (cmd_i),
    .chan_i             (chan_i),
    .instrument_i       (instrument_i),
    .note_period_i      (note_period_i),
    .effect_word_i      (effect_word_i),
    .default_volume_i   (default_volume_i),
    .default_finetune_i (default_finetune_i),
    .chan_out_o         (chan_out_o),
    .play_period_o      (play_period_o),
    .play_volume_o      (play_volume_o),
    .sample_sel_o       (sample_sel_o),
    .restart_o          (restart_o),
    .start_offset_o     (start_offset_o),
    .flow_code_o        (flow_code_o),
    .flow_param_o       (flow_param_o)
  );

endmodule

// File: rtl/core/tcfx_search.sv
module tcfx_search import tcfx_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        key_i,
  input  logic               eval_i,
  input  logic signed [8:0]  offset_i,
  output logic               done_o,
  output logic [15:0]        value_o
);

  logic [ROM_AW-1:0] lo_q, lo_d, hi_q, hi_d, mid;
  logic [15:0]       key_q;
  logic              busy_q, busy_d;
  logic [15:0]       val_q;
  logic signed [12:0] idx_s;
  logic [ROM_AW-1:0] idx_c;

  // Binary search for the first ROM entry at or below the key.
  always_comb begin
    lo_d   = lo_q;
    hi_d   = hi_q;
    busy_d = busy_q;
    mid    = ROM_AW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
    if (start_i) begin
      lo_d   = '0;
      hi_d   = ROM_AW'(ROM_LEN - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (lo_q == hi_q) begin
        busy_d = 1'b0;
      end else if (key_q >= rom_entry(mid)) begin
        hi_d = mid;
      end else begin
        lo_d = ROM_AW'(mid + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (start_i) begin
      key_q <= key_i;
    end
  end

  // Offset lookup from the found index, clamped to the ROM bounds.
  always_comb begin
    idx_s = $signed({2'b00, lo_q}) + 13'(offset_i);
    if (idx_s < 0) begin
      idx_c = '0;
    end else if (idx_s > 13'(ROM_LEN - 1)) begin
      idx_c = ROM_AW'(ROM_LEN - 1);
    end else begin
      idx_c = idx_s[ROM_AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_i) begin
      val_q <= rom_entry(idx_c);
    end
  end

  assign done_o  = !busy_q;
  assign value_o = val_q;

endmodule

// File: rtl/core/tcfx_ctrl.sv
module tcfx_ctrl import tcfx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_FETCH     = 14'b00000000000010,
    S_NOTE_A    = 14'b00000000000100,
    S_FT_WAIT   = 14'b00000000001000,
    S_FT_EVAL   = 14'b00000000010000,
    S_FT_APPLY  = 14'b00000000100000,
    S_NOTE_B    = 14'b00000001000000,
    S_ARP_START = 14'b00000010000000,
    S_ARP_WAIT  = 14'b00000100000000,
    S_ARP_X     = 14'b00001000000000,
    S_ARP_Y     = 14'b00010000000000,
    S_ARP_Z     = 14'b00100000000000,
    S_TICK      = 14'b01000000000000,
    S_OUT       = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Sequencing of one request through the datapath.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        if (!stat_i.chan_ok) begin
          state_d = S_OUT;
        end else if (stat_i.cmd == CMD_NOTE) begin
          state_d = S_NOTE_A;
        end else if (stat_i.cmd == CMD_TICK) begin
          state_d = S_TICK;
        end else begin
          state_d = S_OUT;
        end
      end
      S_NOTE_A: begin
        cmd_o.note_a = 1'b1;
        state_d      = stat_i.need_ft ? S_FT_WAIT : S_NOTE_B;
      end
      S_FT_WAIT: begin
        if (stat_i.search_done) begin
          state_d = S_FT_EVAL;
        end
      end
      S_FT_EVAL: begin
        cmd_o.ft_eval = 1'b1;
        state_d       = S_FT_APPLY;
      end
      S_FT_APPLY: begin
        cmd_o.ft_apply = 1'b1;
        state_d        = S_NOTE_B;
      end
      S_NOTE_B: begin
        cmd_o.note_b = 1'b1;
        state_d      = stat_i.need_arp ? S_ARP_START : S_OUT;
      end
      S_ARP_START: begin
        cmd_o.arp_start = 1'b1;
        state_d         = S_ARP_WAIT;
      end
      S_ARP_WAIT: begin
        if (stat_i.search_done) begin
          state_d = S_ARP_X;
        end
      end
      S_ARP_X: begin
        cmd_o.arp_x = 1'b1;
        state_d     = S_ARP_Y;
      end
      S_ARP_Y: begin
        cmd_o.arp_y = 1'b1;
        state_d     = S_ARP_Z;
      end
      S_ARP_Z: begin
        cmd_o.arp_z = 1'b1;
        state_d     = S_OUT;
      end
      S_TICK: begin
        cmd_o.tick = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the result is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/tcfx_dp.sv
module tcfx_dp import tcfx_pkg::*; #(
  parameter int CHANNELS    = 32,
  parameter int INSTRUMENTS = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output dp_stat_t           stat_o,
  input  logic [1:0]         cmd_in_i,
  input  logic [4:0]         chan_i,
  input  logic [4:0]         instrument_i,
  input  logic [11:0]        note_period_i,
  input  logic [11:0]        effect_word_i,
  input  logic [6:0]         default_volume_i,
  input  logic [3:0]         default_finetune_i,
  output logic [4:0]         chan_out_o,
  output logic signed [15:0] play_period_o,
  output logic [7:0]         play_volume_o,
  output logic [4:0]         sample_sel_o,
  output logic               restart_o,
  output logic [15:0]        start_offset_o,
  output logic [2:0]         flow_code_o,
  output logic [7:0]         flow_param_o
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IW = $clog2(INSTRUMENTS);

  localparam chan_rec_t REC_RESET = '{period: PERIOD_RESET, default: '0};

  // Request fields held for the whole request.
  logic [1:0]  cmd_q;
  logic [4:0]  chan_q, ins_q;
  logic [11:0] np_q, ew_q;

  // Channel state memory, instrument table and working copy.
  chan_rec_t         mem_q [CHANNELS];
  logic [CHANNELS-1:0] vld_q;
  chan_rec_t         rd_q;
  logic              rd_vld_q;
  logic [10:0]       itab_q [INSTRUMENTS];
  chan_rec_t         w_q, w_d;
  logic [15:0]       per_q, per_d;
  logic              restart_q, restart_d;
  logic [15:0]       offs_q, offs_d;
  logic [2:0]        flow_q, flow_d;
  logic [7:0]        fparam_q, fparam_d;

  logic              chan_ok;
  logic [3:0]        fx, x, y;
  logic [7:0]        prm;
  logic              note_any;
  logic [4:0]        new_ins;
  logic [10:0]       ent;
  logic [15:0]       cur_per, p_tmp;
  logic [7:0]        v_tmp;
  logic [1:0]        s_idx;
  logic [5:0]        ph;
  logic [11:0]       vib_prod;
  logic [4:0]        vib_v;

  logic              s_start, s_eval, s_done;
  logic [15:0]       s_key, s_val;
  logic signed [8:0] s_off;

  assign chan_ok = ({1'b0, chan_q} < 6'(CHANNELS));
  assign fx  = ew_q[11:8];
  assign prm = ew_q[7:0];
  assign x   = ew_q[7:4];
  assign y   = ew_q[3:0];
  assign note_any = (np_q != 12'd0) || (ins_q != 5'd0);
  assign new_ins  = (ins_q != 5'd0) ? 5'(ins_q - 5'd1) : w_q.instr;
  assign ent = ({1'b0, new_ins} < 6'(INSTRUMENTS)) ? itab_q[new_ins[IW-1:0]] : 11'd0;
  assign cur_per = (np_q != 12'd0) ? per_q : w_q.period;

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q  <= cmd_in_i;
      chan_q <= chan_i;
      ins_q  <= instrument_i;
      np_q   <= note_period_i;
      ew_q   <= effect_word_i;
    end
  end

  // Instrument defaults are written when a load request is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < INSTRUMENTS; i++) begin
        itab_q[i] <= '0;
      end
    end else if (cmd_i.accept && cmd_in_i == CMD_LOAD && instrument_i != 5'd0 &&
                 {1'b0, instrument_i} <= 6'(INSTRUMENTS)) begin
      itab_q[IW'(instrument_i - 5'd1)] <= {default_volume_i, default_finetune_i};
    end
  end

  // Channel memory: registered read on accept, write back on result load.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q     <= mem_q[chan_i[CW-1:0]];
      rd_vld_q <= vld_q[chan_i[CW-1:0]];
    end
    if (cmd_i.out_load && chan_ok) begin
      mem_q[chan_q[CW-1:0]] <= w_q;
    end
  end

  // An entry never written reads as its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.out_load && chan_ok) begin
      vld_q[chan_q[CW-1:0]] <= 1'b1;
    end
  end

  // Note, tick and arpeggio updates of the working record.
  always_comb begin
    w_d       = w_q;
    per_d     = per_q;
    restart_d = restart_q;
    offs_d    = offs_q;
    flow_d    = flow_q;
    fparam_d  = fparam_q;
    p_tmp     = '0;
    v_tmp     = '0;
    s_idx     = '0;
    ph        = w_q.vib_phase;
    vib_prod  = 12'(w_q.vib_param[3:0] * SINE_HALF[ph[4:0]]);
    vib_v     = vib_prod[11:7];

    if (cmd_i.accept) begin
      restart_d = 1'b0;
      offs_d    = '0;
      flow_d    = FLOW_NONE;
      fparam_d  = '0;
    end

    if (cmd_i.fetch) begin
      w_d = rd_vld_q ? rd_q : REC_RESET;
    end

    if (cmd_i.note_a) begin
      per_d = {4'd0, np_q};
      if (note_any) begin
        w_d.instr    = new_ins;
        w_d.finetune = ent[3:0];
        if (fx != FX_VIB && fx != FX_VIB_VOL) begin
          w_d.vib_off   = '0;
          w_d.vib_phase = '0;
        end
        if (ins_q != 5'd0 && fx != FX_TONE_VOL) begin
          w_d.volume    = {1'b0, ent[10:4]};
          w_d.vol_slide = '0;
        end
        restart_d = (fx != FX_TONE) && (fx != FX_TONE_VOL) && (np_q != 12'd0);
        w_d.arp_off = '0;
      end
    end

    if (cmd_i.ft_apply) begin
      per_d = s_val;
    end

    if (cmd_i.note_b) begin
      w_d.period = cur_per;
      w_d.effect = FX_ARP;
      w_d.param  = '0;
      case (fx)
        FX_ARP: begin
          if (prm != 8'd0) begin
            w_d.param    = prm;
            w_d.arp_step = '0;
            w_d.arp[0]   = cur_per;
          end
        end
        FX_PORT_UP, FX_PORT_DN: begin
          w_d.effect = fx;
          w_d.param  = prm;
        end
        FX_TONE, FX_TONE_VOL: begin
          w_d.effect = fx;
          if (np_q != 12'd0 && per_q != 16'd0) begin
            w_d.slide_target = per_q;
            w_d.period       = w_q.period;
          end
          if (prm != 8'd0) begin
            if (fx == FX_TONE) begin
              w_d.slide_speed = prm;
            end else begin
              w_d.vol_slide = prm;
            end
          end
        end
        FX_VIB: begin
          w_d.effect = fx;
          if (prm != 8'd0) begin
            w_d.vib_param = prm;
          end
        end
        FX_VIB_VOL: begin
          w_d.effect = fx;
          if (prm != 8'd0) begin
            w_d.vol_slide = prm;
          end
        end
        FX_OFFSET: begin
          restart_d = 1'b1;
          offs_d    = {x, y, 8'd0};
        end
        FX_VOL_SLIDE: begin
          w_d.effect    = fx;
          w_d.vol_slide = prm;
        end
        FX_JUMP: begin
          flow_d   = FLOW_JUMP;
          fparam_d = prm;
        end
        FX_SET_VOL: begin
          w_d.volume = prm;
        end
        FX_BREAK: begin
          flow_d   = FLOW_BREAK;
          fparam_d = prm;
        end
        FX_EXT: begin
          case (x)
            EX_FINE_UP: begin
              p_tmp      = cur_per - {12'd0, y};
              w_d.period = (p_tmp < PERIOD_MIN) ? PERIOD_MIN : p_tmp;
            end
            EX_FINE_DN: begin
              p_tmp      = cur_per + {12'd0, y};
              w_d.period = (p_tmp > PERIOD_FINE_HI) ? PERIOD_FINE_HI : p_tmp;
            end
            EX_LOOP: begin
              flow_d   = FLOW_LOOP;
              fparam_d = {4'd0, y};
            end
            EX_FVOL_UP: begin
              v_tmp      = w_q.volume + {4'd0, y};
              w_d.volume = (v_tmp > VOL_MAX) ? VOL_MAX : v_tmp;
            end
            EX_FVOL_DN: begin
              v_tmp      = w_q.volume - {4'd0, y};
              w_d.volume = (v_tmp > VOL_WRAP_LIM) ? 8'd0 : v_tmp;
            end
            EX_DELAY: begin
              flow_d   = FLOW_DELAY;
              fparam_d = {4'd0, y};
            end
            default: begin
            end
          endcase
        end
        FX_SPEED: begin
          if (prm >= SPEED_LIMIT) begin
            flow_d   = FLOW_TEMPO;
            fparam_d = prm;
          end else if (prm != 8'd0) begin
            flow_d   = FLOW_SPEED;
            fparam_d = prm;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.arp_y) begin
      w_d.arp[1] = s_val;
    end
    if (cmd_i.arp_z) begin
      w_d.arp[2] = s_val;
    end

    if (cmd_i.tick) begin
      case (w_q.effect)
        FX_ARP: begin
          if (w_q.param != 8'd0) begin
            s_idx        = (w_q.arp_step > 2'd2) ? 2'd0 : w_q.arp_step;
            w_d.arp_off  = w_q.period - w_q.arp[s_idx];
            w_d.arp_step = (s_idx == 2'd2) ? 2'd0 : 2'(s_idx + 2'd1);
          end
        end
        FX_PORT_UP: begin
          p_tmp      = w_q.period - {8'd0, w_q.param};
          w_d.period = (p_tmp < PERIOD_MIN || p_tmp > PERIOD_MAX) ? PERIOD_MIN : p_tmp;
        end
        FX_PORT_DN: begin
          p_tmp      = w_q.period + {8'd0, w_q.param};
          w_d.period = (p_tmp > PERIOD_MAX) ? PERIOD_MAX : p_tmp;
        end
        FX_TONE, FX_TONE_VOL: begin
          if (w_q.period != w_q.slide_target && w_q.slide_target != 16'd0) begin
            if (w_q.period > w_q.slide_target) begin
              w_d.period = (w_q.period - w_q.slide_target >= {8'd0, w_q.slide_speed}) ?
                           w_q.period - {8'd0, w_q.slide_speed} : w_q.slide_target;
            end else begin
              w_d.period = (w_q.slide_target - w_q.period >= {8'd0, w_q.slide_speed}) ?
                           w_q.period + {8'd0, w_q.slide_speed} : w_q.slide_target;
            end
          end
          if (w_q.effect == FX_TONE_VOL) begin
            w_d.volume = vol_step(w_q.volume, w_q.vol_slide, VOL_TONE_MAX, 8'hFF,
                                  VOL_TONE_MAX);
          end
        end
        FX_VIB, FX_VIB_VOL: begin
          w_d.vib_off   = ph[5] ? 16'(-{11'd0, vib_v}) : {11'd0, vib_v};
          w_d.vib_phase = 6'(ph + {2'd0, w_q.vib_param[7:4]});
          if (w_q.effect == FX_VIB_VOL) begin
            w_d.volume = vol_step(w_q.volume, w_q.vol_slide, VOL_MAX, 8'hFF, VOL_TONE_MAX);
          end
        end
        FX_VOL_SLIDE: begin
          w_d.volume = vol_step(w_q.volume, w_q.vol_slide, VOL_MAX, 8'h0F, VOL_MAX);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    w_q       <= w_d;
    per_q     <= per_d;
    restart_q <= restart_d;
    offs_q    <= offs_d;
    flow_q    <= flow_d;
    fparam_q  <= fparam_d;
  end

  // Period search unit, shared by finetune and arpeggio setup.
  assign s_start = (cmd_i.note_a && stat_o.need_ft) || cmd_i.arp_start;
  assign s_key   = cmd_i.arp_start ? w_q.period : {4'd0, np_q};
  assign s_eval  = cmd_i.ft_eval || cmd_i.arp_x || cmd_i.arp_y;

  always_comb begin
    if (cmd_i.ft_eval) begin
      s_off = {{5{w_q.finetune[3]}}, w_q.finetune};
    end else if (cmd_i.arp_x) begin
      s_off = {2'b00, x, 3'b000};
    end else begin
      s_off = {2'b00, y, 3'b000};
    end
  end

  tcfx_search u_search (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (s_start),
    .key_i    (s_key),
    .eval_i   (s_eval),
    .offset_i (s_off),
    .done_o   (s_done),
    .value_o  (s_val)
  );

  // Status to the controller.
  always_comb begin
    stat_o.cmd         = cmd_q;
    stat_o.chan_ok     = chan_ok;
    stat_o.need_ft     = (np_q != 12'd0) && (ent[3:0] != 4'd0);
    stat_o.need_arp    = (fx == FX_ARP) && (prm != 8'd0);
    stat_o.search_done = s_done;
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      chan_out_o <= chan_q;
      if (chan_ok) begin
        play_period_o  <= $signed(w_q.period - w_q.arp_off - w_q.vib_off);
        play_volume_o  <= w_q.volume;
        sample_sel_o   <= w_q.instr;
        restart_o      <= restart_q;
        start_offset_o <= offs_q;
        flow_code_o    <= flow_q;
        flow_param_o   <= fparam_q;
      end else begin
        play_period_o  <= '0;
        play_volume_o  <= '0;
        sample_sel_o   <= '0;
        restart_o      <= 1'b0;
        start_offset_o <= '0;
        flow_code_o    <= FLOW_NONE;
        flow_param_o   <= '0;
      end
    end
  end

endmodule

// File: rtl/core/tcfx_checker.sv
module tcfx_checker import tcfx_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] start_offset_o,
  input logic [2:0]  flow_code_o,
  input logic [7:0]  flow_param_o
);

  // A held result stays valid until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // After a request is taken the engine is not ready in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("engine took a request while busy");

  // Song-flow codes stay within their defined range.
  a_flow_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> flow_code_o <= FLOW_TEMPO)
    else $error("flow code out of range");

  // No flow effect means no flow parameter; offsets are whole pages.
  a_flow_param: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (flow_code_o != FLOW_NONE || flow_param_o == 8'd0) &&
                    start_offset_o[7:0] == 8'd0)
    else $error("inconsistent flow parameter or offset");

endmodule

bind tracker_channel_effect_engine_top tcfx_checker u_tcfx_checker (.*);
